>>> src/assert_macros.svh
// Assertion macros for the ray and triangle test pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTO_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTO_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/rto_pkg.sv
// Package with widths, types and helpers for the ray and triangle test.
package rto_pkg;

  localparam int CoordBits = 32;
  localparam int RegBits = 32;
  localparam int FracBits = 16;
  localparam int DiffBits = RegBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int CrossLowBits = 34;
  localparam int CrossHighBits = CrossBits - CrossLowBits;
  localparam int LowProdBits = CrossLowBits + 1 + DiffBits;
  localparam int HighProdBits = CrossHighBits + DiffBits;
  localparam int NumBits = CrossBits + DiffBits + 2;
  localparam int ChunkBits = 32;
  localparam int NumChunks = (NumBits + ChunkBits - 1) / ChunkBits;
  localparam int PadBits = NumChunks * ChunkBits;
  localparam int LimPartBits = ChunkBits + 1 + RegBits;
  localparam int LimBits = NumBits + RegBits;
  localparam int IndexBits = 4;

  typedef enum logic [IndexBits-1:0] {
    REG_ORIGIN_X    = 4'd0,
    REG_ORIGIN_Y    = 4'd1,
    REG_ORIGIN_Z    = 4'd2,
    REG_DIRECTION_X = 4'd3,
    REG_DIRECTION_Y = 4'd4,
    REG_DIRECTION_Z = 4'd5,
    REG_NEAR_LIMIT  = 4'd6,
    REG_FAR_LIMIT   = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [RegBits-1:0] origin_x;
    logic signed [RegBits-1:0] origin_y;
    logic signed [RegBits-1:0] origin_z;
    logic signed [RegBits-1:0] direction_x;
    logic signed [RegBits-1:0] direction_y;
    logic signed [RegBits-1:0] direction_z;
    logic signed [RegBits-1:0] near_limit;
    logic signed [RegBits-1:0] far_limit;
  } ray_t;

  typedef struct packed {
    logic signed [RegBits-1:0] x;
    logic signed [RegBits-1:0] y;
    logic signed [RegBits-1:0] z;
  } cvec_t;

  typedef struct packed {
    cvec_t a;
    cvec_t b;
    cvec_t c;
  } tri_t;

  typedef struct packed {
    logic signed [DiffBits-1:0] x;
    logic signed [DiffBits-1:0] y;
    logic signed [DiffBits-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [CrossBits-1:0] x;
    logic signed [CrossBits-1:0] y;
    logic signed [CrossBits-1:0] z;
  } xvec_t;

  typedef struct packed {
    xvec_t ed;
    xvec_t es;
    dvec_t e1;
    dvec_t e2;
    dvec_t s;
    dvec_t d;
  } cross_t;

  typedef struct packed {
    logic signed [NumBits-1:0] det;
    logic signed [NumBits-1:0] ru;
    logic signed [NumBits-1:0] rv;
    logic signed [NumBits-1:0] rt;
  } dot_t;

  // Sign-extends the low coordinate bits of a field to a full register width.
  function automatic logic signed [RegBits-1:0] coord(input logic [RegBits-1:0] v);
    logic signed [CoordBits-1:0] t;
    t = v[CoordBits-1:0];
    return RegBits'(t);
  endfunction

endpackage

>>> src/ray_triangle_occlusion_test.sv
// Top level of the ray and triangle occlusion test with its ray registers.
// Throughput: one triangle per cycle; a stall halts only the stages behind it.
// The ten stages are edges, cross products, cross sums, split dot products,
// term sums, dot sums, sign normalization, limit products, limit sums, compare.
// Reset empties the pipeline and loads the ray registers with their defaults.
module ray_triangle_occlusion_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] vertex_a_x,
  input  logic signed [31:0] vertex_a_y,
  input  logic signed [31:0] vertex_a_z,
  input  logic signed [31:0] vertex_b_x,
  input  logic signed [31:0] vertex_b_y,
  input  logic signed [31:0] vertex_b_z,
  input  logic signed [31:0] vertex_c_x,
  input  logic signed [31:0] vertex_c_y,
  input  logic signed [31:0] vertex_c_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit
);

  rto_pkg::ray_t ray;
  rto_pkg::tri_t tri_in;
  rto_pkg::cross_t cross_beat;
  rto_pkg::dot_t dot_beat;
  logic cross_valid, cross_ready, dot_valid, dot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray.origin_x <= '0;
      ray.origin_y <= '0;
      ray.origin_z <= '0;
      ray.direction_x <= '0;
      ray.direction_y <= '0;
      ray.direction_z <= 32'sd65536;
      ray.near_limit <= '0;
      ray.far_limit <= 32'sd2147483647;
    end else if (cfg_we) begin
      case (rto_pkg::reg_index_t'(cfg_index))
        rto_pkg::REG_ORIGIN_X:    ray.origin_x <= cfg_data;
        rto_pkg::REG_ORIGIN_Y:    ray.origin_y <= cfg_data;
        rto_pkg::REG_ORIGIN_Z:    ray.origin_z <= cfg_data;
        rto_pkg::REG_DIRECTION_X: ray.direction_x <= cfg_data;
        rto_pkg::REG_DIRECTION_Y: ray.direction_y <= cfg_data;
        rto_pkg::REG_DIRECTION_Z: ray.direction_z <= cfg_data;
        rto_pkg::REG_NEAR_LIMIT:  ray.near_limit <= cfg_data;
        rto_pkg::REG_FAR_LIMIT:   ray.far_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tri_in.a.x = vertex_a_x;
    tri_in.a.y = vertex_a_y;
    tri_in.a.z = vertex_a_z;
    tri_in.b.x = vertex_b_x;
    tri_in.b.y = vertex_b_y;
    tri_in.b.z = vertex_b_z;
    tri_in.c.x = vertex_c_x;
    tri_in.c.y = vertex_c_y;
    tri_in.c.z = vertex_c_z;
  end

  rto_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tri_in    (tri_in),
    .ray       (ray),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .cross_out (cross_beat)
  );

  rto_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .cross_in  (cross_beat),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .dot_out   (dot_beat)
  );

  rto_test u_test (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .dot_in    (dot_beat),
    .ray       (ray),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
  );

endmodule

>>> src/rto_cross.sv
// Edge vectors and the two cross products, three pipeline stages.
module rto_cross (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rto_pkg::tri_t     tri_in,
  input  rto_pkg::ray_t     ray,
  output logic              out_valid,
  input  logic              out_ready,
  output rto_pkg::cross_t   cross_out
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  rto_pkg::dvec_t e1, e2, s, d;
  rto_pkg::dvec_t e1_2, e2_2, s_2, d_2;
  logic signed [rto_pkg::ProdBits-1:0] p2 [12];
  rto_pkg::cross_t c3;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;
  assign cross_out = c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      e1.x <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.b.x))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.x));
      e1.y <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.b.y))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.y));
      e1.z <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.b.z))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.z));
      e2.x <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.c.x))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.x));
      e2.y <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.c.y))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.y));
      e2.z <= rto_pkg::DiffBits'(rto_pkg::coord(tri_in.c.z))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.z));
      s.x  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.origin_x))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.x));
      s.y  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.origin_y))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.y));
      s.z  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.origin_z))
            - rto_pkg::DiffBits'(rto_pkg::coord(tri_in.a.z));
      d.x  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.direction_x));
      d.y  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.direction_y));
      d.z  <= rto_pkg::DiffBits'(rto_pkg::coord(ray.direction_z));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p2[0]  <= e1.y * d.z;
      p2[1]  <= e1.z * d.y;
      p2[2]  <= e1.z * d.x;
      p2[3]  <= e1.x * d.z;
      p2[4]  <= e1.x * d.y;
      p2[5]  <= e1.y * d.x;
      p2[6]  <= e2.y * s.z;
      p2[7]  <= e2.z * s.y;
      p2[8]  <= e2.z * s.x;
      p2[9]  <= e2.x * s.z;
      p2[10] <= e2.x * s.y;
      p2[11] <= e2.y * s.x;
      e1_2 <= e1;
      e2_2 <= e2;
      s_2  <= s;
      d_2  <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      c3.ed.x <= rto_pkg::CrossBits'(p2[0]) - rto_pkg::CrossBits'(p2[1]);
      c3.ed.y <= rto_pkg::CrossBits'(p2[2]) - rto_pkg::CrossBits'(p2[3]);
      c3.ed.z <= rto_pkg::CrossBits'(p2[4]) - rto_pkg::CrossBits'(p2[5]);
      c3.es.x <= rto_pkg::CrossBits'(p2[6]) - rto_pkg::CrossBits'(p2[7]);
      c3.es.y <= rto_pkg::CrossBits'(p2[8]) - rto_pkg::CrossBits'(p2[9]);
      c3.es.z <= rto_pkg::CrossBits'(p2[10]) - rto_pkg::CrossBits'(p2[11]);
      c3.e1 <= e1_2;
      c3.e2 <= e2_2;
      c3.s  <= s_2;
      c3.d  <= d_2;
    end
  end

endmodule

>>> src/rto_dot.sv
// Determinant and the three numerators as split dot products, three stages.
module rto_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rto_pkg::cross_t   cross_in,
  output logic              out_valid,
  input  logic              out_ready,
  output rto_pkg::dot_t     dot_out
);

  logic v4, v5, v6;
  logic rdy4, rdy5, rdy6;
  logic signed [rto_pkg::CrossBits-1:0] opa [12];
  logic signed [rto_pkg::DiffBits-1:0] opb [12];
  logic signed [rto_pkg::LowProdBits-1:0] lo4 [12];
  logic signed [rto_pkg::HighProdBits-1:0] hi4 [12];
  logic signed [rto_pkg::NumBits-1:0] t5 [12];
  rto_pkg::dot_t r6;

  assign rdy6 = !v6 || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign in_ready = rdy4;
  assign out_valid = v6;
  assign dot_out = r6;

  always_comb begin
    opa[0]  = cross_in.ed.x;  opb[0]  = cross_in.e2.x;
    opa[1]  = cross_in.ed.y;  opb[1]  = cross_in.e2.y;
    opa[2]  = cross_in.ed.z;  opb[2]  = cross_in.e2.z;
    opa[3]  = cross_in.es.x;  opb[3]  = cross_in.d.x;
    opa[4]  = cross_in.es.y;  opb[4]  = cross_in.d.y;
    opa[5]  = cross_in.es.z;  opb[5]  = cross_in.d.z;
    opa[6]  = cross_in.ed.x;  opb[6]  = cross_in.s.x;
    opa[7]  = cross_in.ed.y;  opb[7]  = cross_in.s.y;
    opa[8]  = cross_in.ed.z;  opb[8]  = cross_in.s.z;
    opa[9]  = cross_in.es.x;  opb[9]  = cross_in.e1.x;
    opa[10] = cross_in.es.y;  opb[10] = cross_in.e1.y;
    opa[11] = cross_in.es.z;  opb[11] = cross_in.e1.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // Each wide operand is split into an unsigned low part and a signed high part.
  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      for (int k = 0; k < 12; k++) begin
        lo4[k] <= $signed({1'b0, opa[k][rto_pkg::CrossLowBits-1:0]}) * opb[k];
        hi4[k] <= $signed(opa[k][rto_pkg::CrossBits-1:rto_pkg::CrossLowBits]) * opb[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      for (int k = 0; k < 12; k++) begin
        t5[k] <= (rto_pkg::NumBits'(hi4[k]) <<< rto_pkg::CrossLowBits)
               + rto_pkg::NumBits'(lo4[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      r6.det <= t5[0] + t5[1] + t5[2];
      r6.ru  <= t5[3] + t5[4] + t5[5];
      r6.rv  <= t5[6] + t5[7] + t5[8];
      r6.rt  <= t5[9] + t5[10] + t5[11];
    end
  end

endmodule

>>> src/rto_test.sv
// Sign normalization, interval products and final bound tests, four stages.
`include "assert_macros.svh"

module rto_test (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rto_pkg::dot_t     dot_in,
  input  rto_pkg::ray_t     ray,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit
);

  logic v7, v8, v9, v10;
  logic rdy7, rdy8, rdy9, rdy10;
  logic neg;
  logic signed [rto_pkg::NumBits-1:0] det7, ru7, rv7, rt7;
  logic zero7;
  logic [rto_pkg::PadBits-1:0] detp;
  logic signed [rto_pkg::LimPartBits-1:0] pn8 [rto_pkg::NumChunks];
  logic signed [rto_pkg::LimPartBits-1:0] pf8 [rto_pkg::NumChunks];
  logic signed [rto_pkg::LimBits-1:0] ts8, ts9, near9, far9;
  logic signed [rto_pkg::LimBits-1:0] near_sum, far_sum;
  logic ok8, ok9;
  logic hit10;

  assign rdy10 = !v10 || out_ready;
  assign rdy9 = !v9 || rdy10;
  assign rdy8 = !v8 || rdy9;
  assign rdy7 = !v7 || rdy8;
  assign in_ready = rdy7;
  assign out_valid = v10;
  assign hit = hit10;
  assign neg = dot_in.det[rto_pkg::NumBits-1];
  assign detp = rto_pkg::PadBits'(unsigned'(det7));

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (rdy7) v7 <= in_valid;
      if (rdy8) v8 <= v7;
      if (rdy9) v9 <= v8;
      if (rdy10) v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && in_valid) begin
      det7  <= neg ? -dot_in.det : dot_in.det;
      ru7   <= neg ? -dot_in.ru : dot_in.ru;
      rv7   <= neg ? -dot_in.rv : dot_in.rv;
      rt7   <= neg ? -dot_in.rt : dot_in.rt;
      zero7 <= (dot_in.det == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy8 && v7) begin
      for (int k = 0; k < rto_pkg::NumChunks; k++) begin
        pn8[k] <= $signed({1'b0, detp[k*rto_pkg::ChunkBits +: rto_pkg::ChunkBits]})
                * ray.near_limit;
        pf8[k] <= $signed({1'b0, detp[k*rto_pkg::ChunkBits +: rto_pkg::ChunkBits]})
                * ray.far_limit;
      end
      ts8 <= rto_pkg::LimBits'(rt7) <<< rto_pkg::FracBits;
      ok8 <= !zero7 && !ru7[rto_pkg::NumBits-1] && !rv7[rto_pkg::NumBits-1]
          && ((rto_pkg::LimBits'(ru7) + rto_pkg::LimBits'(rv7))
              <= rto_pkg::LimBits'(det7));
    end
  end

  always_comb begin
    near_sum = '0;
    far_sum = '0;
    for (int k = 0; k < rto_pkg::NumChunks; k++) begin
      near_sum = near_sum + (rto_pkg::LimBits'(pn8[k]) <<< (k * rto_pkg::ChunkBits));
      far_sum = far_sum + (rto_pkg::LimBits'(pf8[k]) <<< (k * rto_pkg::ChunkBits));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy9 && v8) begin
      near9 <= near_sum;
      far9 <= far_sum;
      ts9 <= ts8;
      ok9 <= ok8;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy10 && v9) begin
      hit10 <= ok9 && (near9 <= ts9) && (ts9 <= far9);
    end
  end

  `RTO_ASSERT_IMP(a_det_normalized, v7 && !zero7, !det7[rto_pkg::NumBits-1], "det not positive")
  `RTO_ASSERT_NXT(a_stall_holds, v7 && !rdy8, v7 && $stable(det7), "stalled beat changed")
  `RTO_ASSERT_NXT(a_beat_moves, v7 && rdy8, v8, "beat lost between stages")

endmodule
